[rtl/heightmap_triangle_height_query_unit_macros.svh]
// assertion macros shared by the terrain height query rtl
// needs a clock signal in the scope of each use, and for HTQ_CHECK a reset signal too
`ifndef HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_UNIT_MACROS_SVH
`define HEIGHTMAP_TRIANGLE_HEIGHT_QUERY_UNIT_MACROS_SVH

// checked only outside reset
`define HTQ_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset as well
`define HTQ_CHECK_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/htq_pkg.sv]
// widths, sizes, codes and helper types for the terrain height query unit
// no dependencies
package htq_pkg;

   localparam int MAX_COLUMNS = 64;
   localparam int MAX_ROWS    = 64;
   localparam int MAX_SIZE    = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
   localparam int CELL_W      = $clog2(MAX_SIZE);
   localparam int SIZE_W      = CELL_W + 1;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int INDEX_W     = 12;
   localparam int HEIGHT_W    = 32;
   localparam int COORD_W     = 32;
   localparam int EXT_W       = 31;
   localparam int SIZE_CFG_W  = 7;
   localparam int CSR_DATA_W  = 31;
   localparam int CSR_INDEX_W = 2;

   localparam int FRAC_BITS   = 16;
   localparam int LQ_BITS     = 24;
   localparam int LOC_W       = LQ_BITS + 2;
   localparam int SC_W        = COORD_W + CELL_W + 1;
   localparam int AXIS_LAT    = CELL_W + LQ_BITS + 5;

   localparam int REQ_FIELDS_W = INDEX_W + HEIGHT_W + 2 * COORD_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_DATA_W   = HEIGHT_W;

   localparam logic [SIZE_CFG_W-1:0] RESET_COLUMNS = 7'd64;
   localparam logic [SIZE_CFG_W-1:0] RESET_ROWS    = 7'd64;
   localparam logic [EXT_W-1:0]      RESET_WIDTH   = 31'd4194304;
   localparam logic [EXT_W-1:0]      RESET_DEPTH   = 31'd4194304;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_GRID_COLUMNS = 2'd0,
      CSR_GRID_ROWS    = 2'd1,
      CSR_WORLD_WIDTH  = 2'd2,
      CSR_WORLD_DEPTH  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      logic [CELL_W-1:0] n_m1;
      logic [CELL_W-1:0] n_m2;
      logic [EXT_W-1:0]  ext;
   } htq_axis_cfg_type;

   function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_CFG_W-1:0] v,
                                                   input int hi);
      int val;
      val = int'(v);
      if (val < 2) begin
         val = 2;
      end else if (val > hi) begin
         val = hi;
      end
      return SIZE_W'(val);
   endfunction

endpackage

[rtl/heightmap_triangle_height_query_unit.sv]
// top level of the terrain height query unit: config, height table, blend pipeline
// depends on htq_pkg, htq_axis, htq_ram and the shared assertion macros
//
//   channel  dir  handshake            payload
//   req      in   req_tvalid/tready    tuser op, tdata index/height/x/z
//   rsp      out  rsp_tvalid/tready    tdata terrain height
//   csr      in   csr_wr_en            csr_index, csr_wdata
//
// one word per cycle while no result word is held; a query word passes through the
// one-bit-per-stage cell and fraction dividers of each axis (35 stages) and
// six stages of table read and blend. reset clears config and valid bits only;
// the height table has no reset. a held result word stalls the whole pipeline.
`include "heightmap_triangle_height_query_unit_macros.svh"

module heightmap_triangle_height_query_unit import htq_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // entry_index, entry_height, query_x, query_z, zero pad
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // op
   input  logic                    req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // terrain_height
   output logic [RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                    csr_wr_en,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int PRW  = LOC_W + HEIGHT_W + 2;
   localparam int SUMW = PRW + 1;
   localparam int QW   = SUMW - FRAC_BITS;
   localparam int RW   = QW + 1;
   localparam int AEW  = CELL_W + SIZE_W + 2;

   // config
   logic [SIZE_CFG_W-1:0] cols_ff;
   logic [SIZE_CFG_W-1:0] rows_ff;
   logic [EXT_W-1:0]      width_ff;
   logic [EXT_W-1:0]      depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff  <= RESET_COLUMNS;
         rows_ff  <= RESET_ROWS;
         width_ff <= RESET_WIDTH;
         depth_ff <= RESET_DEPTH;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_GRID_COLUMNS: cols_ff  <= csr_wdata[SIZE_CFG_W-1:0];
            CSR_GRID_ROWS:    rows_ff  <= csr_wdata[SIZE_CFG_W-1:0];
            CSR_WORLD_WIDTH:  width_ff <= csr_wdata[EXT_W-1:0];
            CSR_WORLD_DEPTH:  depth_ff <= csr_wdata[EXT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIZE_W-1:0] cols_eff;
   logic [SIZE_W-1:0] rows_eff;
   htq_axis_cfg_type  ax_cfg_x;
   htq_axis_cfg_type  ax_cfg_z;

   assign cols_eff      = clamp_size(cols_ff, MAX_COLUMNS);
   assign rows_eff      = clamp_size(rows_ff, MAX_ROWS);
   assign ax_cfg_x.n_m1 = CELL_W'(cols_eff - SIZE_W'(1));
   assign ax_cfg_x.n_m2 = CELL_W'(cols_eff - SIZE_W'(2));
   assign ax_cfg_x.ext  = (width_ff == '0) ? EXT_W'(1) : width_ff;
   assign ax_cfg_z.n_m1 = CELL_W'(rows_eff - SIZE_W'(1));
   assign ax_cfg_z.n_m2 = CELL_W'(rows_eff - SIZE_W'(2));
   assign ax_cfg_z.ext  = (depth_ff == '0) ? EXT_W'(1) : depth_ff;

   // handshake
   logic adv;
   logic acc;
   logic rsp_valid_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign acc        = req_tvalid && adv;

   logic [INDEX_W-1:0]         in_index;
   logic [HEIGHT_W-1:0]        in_height;
   logic signed [COORD_W-1:0]  in_x;
   logic signed [COORD_W-1:0]  in_z;

   assign in_index  = req_tdata[INDEX_W-1:0];
   assign in_height = req_tdata[INDEX_W+HEIGHT_W-1:INDEX_W];
   assign in_x      = $signed(req_tdata[INDEX_W+HEIGHT_W+COORD_W-1:INDEX_W+HEIGHT_W]);
   assign in_z      = $signed(req_tdata[REQ_FIELDS_W-1:INDEX_W+HEIGHT_W+COORD_W]);

   // axis dividers and the matching delay line
   logic [CELL_W-1:0]       cell_x;
   logic [CELL_W-1:0]       cell_z;
   logic signed [LOC_W-1:0] loc_u;
   logic signed [LOC_W-1:0] loc_v;

   htq_axis u_axis_x (
      .clock    (clock),
      .en       (adv),
      .cfg      (ax_cfg_x),
      .coord    (in_x),
      .cell_idx (cell_x),
      .loc      (loc_u)
   );

   htq_axis u_axis_z (
      .clock    (clock),
      .en       (adv),
      .cfg      (ax_cfg_z),
      .coord    (in_z),
      .cell_idx (cell_z),
      .loc      (loc_v)
   );

   logic                dv_ff   [AXIS_LAT];
   op_type              dop_ff  [AXIS_LAT];
   logic [ADDR_W-1:0]   didx_ff [AXIS_LAT];
   logic [HEIGHT_W-1:0] dh_ff   [AXIS_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < AXIS_LAT; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         dv_ff[0] <= acc;
         for (int k = 1; k < AXIS_LAT; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dop_ff[0]  <= op_type'(req_tuser);
         didx_ff[0] <= ADDR_W'(in_index);
         dh_ff[0]   <= in_height;
         for (int k = 1; k < AXIS_LAT; k++) begin
            dop_ff[k]  <= dop_ff[k-1];
            didx_ff[k] <= didx_ff[k-1];
            dh_ff[k]   <= dh_ff[k-1];
         end
      end
   end

   // corner addresses and triangle choice
   logic [AEW-1:0]          base0;
   logic [AEW-1:0]          base1;
   logic                    lower;
   logic                    hv_ff;
   op_type                  hop_ff;
   logic [ADDR_W-1:0]       hidx_ff;
   logic [HEIGHT_W-1:0]     hh_ff;
   logic [ADDR_W-1:0]       abl_ff;
   logic [ADDR_W-1:0]       atr_ff;
   logic [ADDR_W-1:0]       a3_ff;
   logic                    hlower_ff;
   logic signed [LOC_W-1:0] hu_ff;
   logic signed [LOC_W-1:0] hvl_ff;

   assign base0 = AEW'(cell_z) * AEW'(cols_eff);
   assign base1 = (AEW'(cell_z) + AEW'(1)) * AEW'(cols_eff);
   assign lower = loc_v < loc_u;

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff <= 1'b0;
      end else if (adv) begin
         hv_ff <= dv_ff[AXIS_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hop_ff    <= dop_ff[AXIS_LAT-1];
         hidx_ff   <= didx_ff[AXIS_LAT-1];
         hh_ff     <= dh_ff[AXIS_LAT-1];
         abl_ff    <= ADDR_W'(base0 + AEW'(cell_x));
         atr_ff    <= ADDR_W'(base1 + AEW'(cell_x) + AEW'(1));
         a3_ff     <= lower ? ADDR_W'(base0 + AEW'(cell_x) + AEW'(1))
                            : ADDR_W'(base1 + AEW'(cell_x));
         hlower_ff <= lower;
         hu_ff     <= loc_u;
         hvl_ff    <= loc_v;
      end
   end

   // height table, one copy per corner
   logic                ram_we;
   logic [HEIGHT_W-1:0] h_bl;
   logic [HEIGHT_W-1:0] h_tr;
   logic [HEIGHT_W-1:0] h_3;

   assign ram_we = hv_ff && (hop_ff == OP_WRITE) && adv;

   htq_ram #(.WIDTH(HEIGHT_W), .DEPTH(TABLE_DEPTH)) u_ram_bl (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (hidx_ff),
      .wr_data (hh_ff),
      .rd_en   (adv),
      .rd_addr (abl_ff),
      .rd_data (h_bl)
   );

   htq_ram #(.WIDTH(HEIGHT_W), .DEPTH(TABLE_DEPTH)) u_ram_tr (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (hidx_ff),
      .wr_data (hh_ff),
      .rd_en   (adv),
      .rd_addr (atr_ff),
      .rd_data (h_tr)
   );

   htq_ram #(.WIDTH(HEIGHT_W), .DEPTH(TABLE_DEPTH)) u_ram_3 (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (hidx_ff),
      .wr_data (hh_ff),
      .rd_en   (adv),
      .rd_addr (a3_ff),
      .rd_data (h_3)
   );

   // weights, alongside the table read
   logic [LOC_W-1:0]          abs_u;
   logic [LOC_W-1:0]          abs_v;
   logic signed [LOC_W:0]     dvu;
   logic                      iv_ff;
   logic [LOC_W-1:0]          wtr_ff;
   logic [LOC_W-1:0]          w3_ff;

   assign abs_u = hu_ff[LOC_W-1] ? LOC_W'(-hu_ff) : LOC_W'(hu_ff);
   assign abs_v = hvl_ff[LOC_W-1] ? LOC_W'(-hvl_ff) : LOC_W'(hvl_ff);
   assign dvu   = {hvl_ff[LOC_W-1], hvl_ff} - {hu_ff[LOC_W-1], hu_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_ff <= 1'b0;
      end else if (adv) begin
         iv_ff <= hv_ff && (hop_ff == OP_QUERY);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         wtr_ff <= hlower_ff ? abs_v : abs_u;
         w3_ff  <= dvu[LOC_W] ? LOC_W'(-dvu) : LOC_W'(dvu);
      end
   end

   // differences, products, rounding, saturation
   logic                       jv_ff;
   logic signed [HEIGHT_W:0]   dtr_ff;
   logic signed [HEIGHT_W:0]   d3_ff;
   logic signed [HEIGHT_W-1:0] hbl_j_ff;
   logic [LOC_W-1:0]           wtr_j_ff;
   logic [LOC_W-1:0]           w3_j_ff;
   logic                       kv_ff;
   logic signed [PRW-1:0]      ptr_ff;
   logic signed [PRW-1:0]      p3_ff;
   logic signed [HEIGHT_W-1:0] hbl_k_ff;
   logic                       lv_ff;
   logic signed [QW-1:0]       lq_ff;
   logic signed [HEIGHT_W-1:0] hbl_l_ff;
   logic signed [SUMW-1:0]     sum;
   logic signed [RW-1:0]       res;
   logic                       res_ovf;
   logic [RSP_DATA_W-1:0]      rsp_data_ff;

   assign sum = {ptr_ff[PRW-1], ptr_ff} + {p3_ff[PRW-1], p3_ff}
              + $signed(SUMW'(1) << (FRAC_BITS - 1));
   assign res = {{(RW-HEIGHT_W){hbl_l_ff[HEIGHT_W-1]}}, hbl_l_ff}
              + {lq_ff[QW-1], lq_ff};
   assign res_ovf = !((&res[RW-1:HEIGHT_W-1]) || !(|res[RW-1:HEIGHT_W-1]));

   always_ff @(posedge clock) begin
      if (reset) begin
         jv_ff        <= 1'b0;
         kv_ff        <= 1'b0;
         lv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         jv_ff        <= iv_ff;
         kv_ff        <= jv_ff;
         lv_ff        <= kv_ff;
         rsp_valid_ff <= lv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dtr_ff   <= $signed({h_tr[HEIGHT_W-1], h_tr}) - $signed({h_bl[HEIGHT_W-1], h_bl});
         d3_ff    <= $signed({h_3[HEIGHT_W-1], h_3}) - $signed({h_bl[HEIGHT_W-1], h_bl});
         hbl_j_ff <= $signed(h_bl);
         wtr_j_ff <= wtr_ff;
         w3_j_ff  <= w3_ff;
         ptr_ff   <= $signed({1'b0, wtr_j_ff}) * dtr_ff;
         p3_ff    <= $signed({1'b0, w3_j_ff}) * d3_ff;
         hbl_k_ff <= hbl_j_ff;
         lq_ff    <= QW'(sum >>> FRAC_BITS);
         hbl_l_ff <= hbl_k_ff;
         if (res_ovf) begin
            rsp_data_ff <= {res[RW-1], {(RSP_DATA_W-1){!res[RW-1]}}};
         end else begin
            rsp_data_ff <= RSP_DATA_W'(res);
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `HTQ_CHECK(a_no_write_on_stall, !adv |-> !ram_we, "height table written during a stall")
   `HTQ_CHECK_RST(a_reset_empties, reset |=> !rsp_valid_ff, "result word valid after reset")
   `HTQ_CHECK(a_cell_in_grid, dv_ff[AXIS_LAT-1] |-> (cell_x <= ax_cfg_x.n_m2) && (cell_z <= ax_cfg_z.n_m2), "cell index beyond grid")
   `HTQ_CHECK(a_write_no_result, (hv_ff && (hop_ff == OP_WRITE) && adv) |=> !iv_ff, "write word turned into a result")

endmodule

[rtl/htq_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
module htq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/htq_axis.sv]
// one axis of the query: cell index and local signed q9.16 offset by pipelined division
// depends on htq_pkg
module htq_axis import htq_pkg::*; (
   input  logic                       clock,
   input  logic                       en,
   input  htq_axis_cfg_type           cfg,
   input  logic signed [COORD_W-1:0]  coord,
   output logic [CELL_W-1:0]          cell_idx,
   output logic signed [LOC_W-1:0]    loc
);

   localparam int DW = SC_W - 1;
   localparam int BW = (DW > EXT_W + CELL_W) ? DW : EXT_W + CELL_W;
   localparam int FW = (DW + FRAC_BITS > EXT_W + LQ_BITS) ? DW + FRAC_BITS : EXT_W + LQ_BITS;
   localparam int PW = CELL_W + EXT_W;

   // scale
   logic signed [SC_W-1:0] coord_ext;
   logic signed [SC_W-1:0] n_ext;
   logic signed [SC_W-1:0] sc_a_ff;

   assign coord_ext = {{(SC_W-COORD_W){coord[COORD_W-1]}}, coord};
   assign n_ext     = $signed(SC_W'(cfg.n_m1));

   always_ff @(posedge clock) begin
      if (en) begin
         sc_a_ff <= coord_ext * n_ext;
      end
   end

   // cell quotient, one bit per stage
   logic [BW-1:0]          b_r_src   [CELL_W+1];
   logic [CELL_W-1:0]      b_q_src   [CELL_W+1];
   logic                   b_ovf_src [CELL_W+1];
   logic signed [SC_W-1:0] b_sc_src  [CELL_W+1];
   logic [BW-1:0]          br_in     [CELL_W];
   logic [CELL_W-1:0]      bq_in     [CELL_W];
   logic [BW-1:0]          br_ff     [CELL_W];
   logic [CELL_W-1:0]      bq_ff     [CELL_W];
   logic                   bovf_ff   [CELL_W];
   logic signed [SC_W-1:0] bsc_ff    [CELL_W];

   always_comb begin
      logic [BW-1:0] d;
      b_r_src[0]   = sc_a_ff[SC_W-1] ? '0 : BW'(sc_a_ff[DW-1:0]);
      b_q_src[0]   = '0;
      b_ovf_src[0] = !sc_a_ff[SC_W-1] &&
                     (BW'(sc_a_ff[DW-1:0]) >= (BW'(cfg.ext) << CELL_W));
      b_sc_src[0]  = sc_a_ff;
      for (int k = 0; k < CELL_W; k++) begin
         d = BW'(cfg.ext) << (CELL_W - 1 - k);
         br_in[k] = b_r_src[k];
         bq_in[k] = b_q_src[k];
         if (b_r_src[k] >= d) begin
            br_in[k] = b_r_src[k] - d;
            bq_in[k][CELL_W-1-k] = 1'b1;
         end
         b_r_src[k+1]   = br_ff[k];
         b_q_src[k+1]   = bq_ff[k];
         b_ovf_src[k+1] = bovf_ff[k];
         b_sc_src[k+1]  = bsc_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < CELL_W; k++) begin
            br_ff[k]   <= br_in[k];
            bq_ff[k]   <= bq_in[k];
            bovf_ff[k] <= b_ovf_src[k];
            bsc_ff[k]  <= b_sc_src[k];
         end
      end
   end

   // clamp, multiply back, remainder
   logic [CELL_W-1:0]      c_in;
   logic [CELL_W-1:0]      c_ff;
   logic signed [SC_W-1:0] csc_ff;
   logic [PW-1:0]          dprod_ff;
   logic [CELL_W-1:0]      dc_ff;
   logic signed [SC_W-1:0] dsc_ff;
   logic signed [SC_W-1:0] num;
   logic                   eneg_ff;
   logic [DW-1:0]          emag_ff;
   logic [CELL_W-1:0]      ec_ff;

   always_comb begin
      if (b_sc_src[CELL_W][SC_W-1]) begin
         c_in = '0;
      end else if (b_ovf_src[CELL_W] || (b_q_src[CELL_W] > cfg.n_m2)) begin
         c_in = cfg.n_m2;
      end else begin
         c_in = b_q_src[CELL_W];
      end
   end

   assign num = dsc_ff - $signed(SC_W'(dprod_ff));

   always_ff @(posedge clock) begin
      if (en) begin
         c_ff     <= c_in;
         csc_ff   <= b_sc_src[CELL_W];
         dprod_ff <= PW'(c_ff) * PW'(cfg.ext);
         dc_ff    <= c_ff;
         dsc_ff   <= csc_ff;
         eneg_ff  <= num[SC_W-1];
         emag_ff  <= num[SC_W-1] ? DW'(-num) : DW'(num);
         ec_ff    <= dc_ff;
      end
   end

   // local fraction quotient, one bit per stage
   logic [FW-1:0]      f_r_src   [LQ_BITS+1];
   logic [LQ_BITS-1:0] f_q_src   [LQ_BITS+1];
   logic               f_ovf_src [LQ_BITS+1];
   logic               f_neg_src [LQ_BITS+1];
   logic [CELL_W-1:0]  f_c_src   [LQ_BITS+1];
   logic [FW-1:0]      fr_in     [LQ_BITS];
   logic [LQ_BITS-1:0] fq_in     [LQ_BITS];
   logic [FW-1:0]      fr_ff     [LQ_BITS];
   logic [LQ_BITS-1:0] fq_ff     [LQ_BITS];
   logic               fovf_ff   [LQ_BITS];
   logic               fneg_ff   [LQ_BITS];
   logic [CELL_W-1:0]  fc_ff     [LQ_BITS];

   always_comb begin
      logic [FW-1:0] d;
      f_r_src[0]   = FW'(emag_ff) << FRAC_BITS;
      f_q_src[0]   = '0;
      f_ovf_src[0] = (FW'(emag_ff) << FRAC_BITS) >= (FW'(cfg.ext) << LQ_BITS);
      f_neg_src[0] = eneg_ff;
      f_c_src[0]   = ec_ff;
      for (int k = 0; k < LQ_BITS; k++) begin
         d = FW'(cfg.ext) << (LQ_BITS - 1 - k);
         fr_in[k] = f_r_src[k];
         fq_in[k] = f_q_src[k];
         if (f_r_src[k] >= d) begin
            fr_in[k] = f_r_src[k] - d;
            fq_in[k][LQ_BITS-1-k] = 1'b1;
         end
         f_r_src[k+1]   = fr_ff[k];
         f_q_src[k+1]   = fq_ff[k];
         f_ovf_src[k+1] = fovf_ff[k];
         f_neg_src[k+1] = fneg_ff[k];
         f_c_src[k+1]   = fc_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < LQ_BITS; k++) begin
            fr_ff[k]   <= fr_in[k];
            fq_ff[k]   <= fq_in[k];
            fovf_ff[k] <= f_ovf_src[k];
            fneg_ff[k] <= f_neg_src[k];
            fc_ff[k]   <= f_c_src[k];
         end
      end
   end

   // saturate and sign
   logic [LQ_BITS:0]        gmag;
   logic signed [LOC_W-1:0] gloc;
   logic signed [LOC_W-1:0] loc_ff;
   logic [CELL_W-1:0]       cell_ff;

   assign gmag = f_ovf_src[LQ_BITS] ? ((LQ_BITS+1)'(1) << LQ_BITS)
                                    : {1'b0, f_q_src[LQ_BITS]};
   assign gloc = f_neg_src[LQ_BITS] ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});

   always_ff @(posedge clock) begin
      if (en) begin
         loc_ff  <= gloc;
         cell_ff <= f_c_src[LQ_BITS];
      end
   end

   assign loc      = loc_ff;
   assign cell_idx = cell_ff;

endmodule
